@@ rtl/gnss_local_xy_projection_core_macros.svh @@
// Assertion macros shared by the projection core modules.
`ifndef GNSS_LOCAL_XY_PROJECTION_CORE_MACROS_SVH
`define GNSS_LOCAL_XY_PROJECTION_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GLXY_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GLXY_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/glxy_pkg.sv @@
// Shared types, constants and tables of the local XY projection core.
`default_nettype none
package glxy_pkg;

    localparam int COS_FRAC_BITS_DEF = 16;
    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int ATAN_COUNT        = 24;
    localparam int ATAN_IDX_W        = 5;
    localparam int ATAN_W            = 29;

    localparam int DIGIT_W    = 16;
    localparam int NUM_DIGITS = 3;
    localparam int MUL_A_W    = 56;
    localparam int MUL_B_W    = DIGIT_W * NUM_DIGITS;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;

    localparam int CFG_W = 23;
    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 144;

    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic [30:0] LAT_LIMIT = 31'd900000000;
    // floor(floor(pi * 2^62) / 1800000)
    localparam logic [42:0] MM_SCALE_Q62 = 43'd8048910508974;
    localparam logic [MUL_A_W-1:0] OUT_LIMIT = MUL_A_W'(64'd34359738367);
    localparam logic [22:0] EARTH_R_RESET = 23'd6378137;

    typedef enum logic [1:0] {
        REQ_FIX      = 2'd0,
        REQ_SET      = 2'd1,
        REQ_SET_LAST = 2'd2,
        REQ_CLEAR    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CFG_AUTO_ORIGIN = 2'd0,
        CFG_EARTH_RN    = 2'd1,
        CFG_EARTH_RM    = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_CINIT,
        S_CORDIC,
        S_CFIN,
        S_CHECK,
        S_MUL,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_PN_LAT,
        OP_NORTH,
        OP_PN_LON,
        OP_T,
        OP_EAST
    } t_mul_op;

    typedef struct packed {
        logic        capture;
        logic        decide;
        logic        cordic_init;
        logic        cordic_step;
        logic        cordic_fin;
        logic        mul_en;
        logic        mul_first;
        logic        mul_last;
        logic [1:0]  mul_digit;
        t_mul_op     mul_op;
        logic        load_out;
    } t_cmd;

    typedef struct packed {
        logic set_origin;
        logic lv;
    } t_status;

    // atan(2^-i) in 1e-7 degrees
    function automatic logic [ATAN_W-1:0] atan_e7(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:  v = 29'd450000000;
            5'd1:  v = 29'd265650512;
            5'd2:  v = 29'd140362435;
            5'd3:  v = 29'd71250163;
            5'd4:  v = 29'd35763344;
            5'd5:  v = 29'd17899106;
            5'd6:  v = 29'd8951737;
            5'd7:  v = 29'd4476142;
            5'd8:  v = 29'd2238105;
            5'd9:  v = 29'd1119057;
            5'd10: v = 29'd559529;
            5'd11: v = 29'd279765;
            5'd12: v = 29'd139882;
            5'd13: v = 29'd69941;
            5'd14: v = 29'd34971;
            5'd15: v = 29'd17485;
            5'd16: v = 29'd8743;
            5'd17: v = 29'd4371;
            5'd18: v = 29'd2186;
            5'd19: v = 29'd1093;
            5'd20: v = 29'd546;
            5'd21: v = 29'd273;
            5'd22: v = 29'd137;
            5'd23: v = 29'd68;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ rtl/glxy_datapath.sv @@
// Datapath: config, origin and last-fix state, CORDIC cosine, digit-serial multiplier.
`default_nettype none
`include "gnss_local_xy_projection_core_macros.svh"
module glxy_datapath
    import glxy_pkg::*;
#(
    parameter int COS_FRAC_BITS = COS_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF,
    parameter int STEP_W        = $clog2(CORDIC_STEPS + 1)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [1:0]             i_cfg_addr,
    input  wire logic [CFG_W-1:0]       i_cfg_wdata,
    input  wire logic [IN_TDATA_W-1:0]  i_in_tdata,
    input  wire logic [IN_TUSER_W-1:0]  i_in_tuser,
    input  wire t_cmd                   i_cmd,
    input  wire logic [STEP_W-1:0]      i_step,
    output t_status                     o_status,
    output logic [OUT_TDATA_W-1:0]      o_out_tdata
);
    localparam int COS_W = COS_FRAC_BITS + 2;
    localparam logic [COS_W-1:0] COS_ONE = COS_W'(1) << COS_FRAC_BITS;

    logic               r_cfg_auto;
    logic [CFG_W-1:0]   r_cfg_rn, r_cfg_rm;

    t_req               r_in_req;
    logic signed [30:0] r_in_lat;
    logic signed [31:0] r_in_lon;
    logic               r_in_valid;

    logic signed [30:0] r_org_lat, r_last_lat;
    logic signed [31:0] r_org_lon, r_last_lon;
    logic               r_origin_valid, r_last_valid, r_ok;
    logic [COS_W-1:0]   r_cos;

    logic signed [33:0] r_x, r_y;
    logic signed [32:0] r_z;

    logic [PROD_W-1:0]  r_acc;
    logic [MUL_A_W-1:0] r_p, r_t, r_north, r_east;
    logic [OUT_TDATA_W-1:0] r_out;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_auto <= 1'b1;
            r_cfg_rn   <= EARTH_R_RESET;
            r_cfg_rm   <= EARTH_R_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_AUTO_ORIGIN: r_cfg_auto <= i_cfg_wdata[0];
                CFG_EARTH_RN:    r_cfg_rn   <= i_cfg_wdata;
                CFG_EARTH_RM:    r_cfg_rm   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_req   <= t_req'(i_in_tuser);
            r_in_lat   <= i_in_tdata[30:0];
            r_in_lon   <= i_in_tdata[62:31];
            r_in_valid <= i_in_tdata[63];
        end
    end

    logic set_origin;
    always_comb begin
        case (r_in_req)
            REQ_FIX:      set_origin = r_cfg_auto && !r_origin_valid && r_in_valid;
            REQ_SET:      set_origin = 1'b1;
            REQ_SET_LAST: set_origin = r_last_valid;
            default:      set_origin = 1'b0;
        endcase
    end
    assign o_status.set_origin = set_origin;
    assign o_status.lv         = r_origin_valid && r_last_valid;

    // cordic cosine
    logic [30:0]        lat_abs, lat_clamped;
    logic signed [33:0] cx_rnd, c_full;
    logic [ATAN_W-1:0]  atan_v;
    always_comb begin
        lat_abs     = r_org_lat[30] ? 31'(-r_org_lat) : 31'(r_org_lat);
        lat_clamped = (lat_abs > LAT_LIMIT) ? LAT_LIMIT : lat_abs;
        atan_v      = atan_e7(ATAN_IDX_W'(i_step));
        cx_rnd      = r_x + (34'sd1 <<< (29 - COS_FRAC_BITS));
        c_full      = cx_rnd >>> (30 - COS_FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cordic_init) begin
            r_x <= CORDIC_GAIN_Q30;
            r_y <= '0;
            r_z <= 33'(signed'({1'b0, lat_clamped}));
        end else if (i_cmd.cordic_step) begin
            if (!r_z[32]) begin
                r_x <= r_x - (r_y >>> i_step);
                r_y <= r_y + (r_x >>> i_step);
                r_z <= r_z - 33'(atan_v);
            end else begin
                r_x <= r_x + (r_y >>> i_step);
                r_y <= r_y - (r_x >>> i_step);
                r_z <= r_z + 33'(atan_v);
            end
        end
    end

    // request handling and origin state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_lat      <= '0;
            r_org_lon      <= '0;
            r_origin_valid <= 1'b0;
            r_cos          <= '0;
            r_last_lat     <= '0;
            r_last_lon     <= '0;
            r_last_valid   <= 1'b0;
            r_ok           <= 1'b1;
        end else if (i_cmd.decide) begin
            r_ok <= !(r_in_req == REQ_SET_LAST && !r_last_valid);
            if (r_in_req == REQ_FIX) begin
                r_last_lat   <= r_in_lat;
                r_last_lon   <= r_in_lon;
                r_last_valid <= r_in_valid;
            end
            if (r_in_req == REQ_CLEAR) begin
                r_org_lat      <= '0;
                r_org_lon      <= '0;
                r_origin_valid <= 1'b0;
                r_cos          <= '0;
            end else if (set_origin) begin
                r_org_lat      <= (r_in_req == REQ_SET_LAST) ? r_last_lat : r_in_lat;
                r_org_lon      <= (r_in_req == REQ_SET_LAST) ? r_last_lon : r_in_lon;
                r_origin_valid <= 1'b1;
            end
        end else if (i_cmd.cordic_fin) begin
            if (c_full < 0)
                r_cos <= '0;
            else if (c_full > 34'(COS_ONE))
                r_cos <= COS_ONE;
            else
                r_cos <= COS_W'(c_full);
        end
    end

    // differences and magnitudes
    logic signed [31:0] dlat;
    logic signed [32:0] dlon;
    logic [31:0]        mag_lat;
    logic [32:0]        mag_lon;
    always_comb begin
        dlat    = 32'(r_last_lat) - 32'(r_org_lat);
        dlon    = 33'(r_last_lon) - 33'(r_org_lon);
        mag_lat = dlat[31] ? 32'(-dlat) : 32'(dlat);
        mag_lon = dlon[32] ? 33'(-dlon) : 33'(dlon);
    end

    // digit-serial multiplier, most significant digit of B first
    logic [MUL_A_W-1:0] a_op;
    logic [MUL_B_W-1:0] b_op;
    logic [DIGIT_W-1:0] digit;
    logic [PROD_W-1:0]  acc_next, rnd;
    always_comb begin
        case (i_cmd.mul_op)
            OP_PN_LAT: begin a_op = MUL_A_W'(mag_lat); b_op = MUL_B_W'(r_cfg_rm); end
            OP_NORTH:  begin a_op = r_p; b_op = MUL_B_W'(MM_SCALE_Q62); end
            OP_PN_LON: begin a_op = MUL_A_W'(mag_lon); b_op = MUL_B_W'(r_cfg_rn); end
            OP_T:      begin a_op = r_p; b_op = MUL_B_W'(MM_SCALE_Q62); end
            default:   begin a_op = r_t; b_op = MUL_B_W'(r_cos); end
        endcase
        case (i_cmd.mul_digit)
            2'd0:    digit = b_op[3*DIGIT_W-1:2*DIGIT_W];
            2'd1:    digit = b_op[2*DIGIT_W-1:DIGIT_W];
            default: digit = b_op[DIGIT_W-1:0];
        endcase
        acc_next = (i_cmd.mul_first ? '0 : (r_acc << DIGIT_W))
                 + (PROD_W'(a_op) * PROD_W'(digit));
        case (i_cmd.mul_op)
            OP_NORTH: rnd = (acc_next + (PROD_W'(1) << 61)) >> 62;
            OP_T:     rnd = (acc_next + (PROD_W'(1) << 45)) >> 46;
            OP_EAST:  rnd = (acc_next + (PROD_W'(1) << (COS_FRAC_BITS + 15)))
                            >> (COS_FRAC_BITS + 16);
            default:  rnd = acc_next;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_acc <= acc_next;
            if (i_cmd.mul_last) begin
                case (i_cmd.mul_op)
                    OP_PN_LAT, OP_PN_LON: r_p <= rnd[MUL_A_W-1:0];
                    OP_NORTH:             r_north <= rnd[MUL_A_W-1:0];
                    OP_T:                 r_t <= rnd[MUL_A_W-1:0];
                    default:              r_east <= rnd[MUL_A_W-1:0];
                endcase
            end
        end
    end

    // result assembly
    logic [35:0] east_sat, north_sat, east_o, north_o;
    logic        lv;
    always_comb begin
        lv        = r_origin_valid && r_last_valid;
        east_sat  = (r_east > OUT_LIMIT) ? OUT_LIMIT[35:0] : r_east[35:0];
        north_sat = (r_north > OUT_LIMIT) ? OUT_LIMIT[35:0] : r_north[35:0];
        east_o    = !lv ? '0 : (dlon[32] ? -east_sat : east_sat);
        north_o   = !lv ? '0 : (dlat[31] ? -north_sat : north_sat);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= {6'd0, r_ok, r_origin_valid,
                      r_origin_valid ? r_org_lon : 32'd0,
                      r_origin_valid ? r_org_lat : 31'd0,
                      lv, north_o, east_o};
        end
    end
    assign o_out_tdata = r_out;

    `GLXY_ASSERT_IMP(a_cos_range, i_clk, i_rst_n, 1'b1, r_cos <= COS_ONE, "cosine above one")
    `GLXY_ASSERT_IMP(a_cos_no_origin, i_clk, i_rst_n, !r_origin_valid, r_cos == '0,
        "cosine nonzero without origin")
    `GLXY_ASSERT_IMP(a_step_in_range, i_clk, i_rst_n, i_cmd.cordic_step,
        i_step < STEP_W'(CORDIC_STEPS), "CORDIC step index out of range")
endmodule
`default_nettype wire

@@ rtl/glxy_ctrl.sv @@
// Controller: sequences request decode, CORDIC steps, multiplies and result handoff.
`default_nettype none
`include "gnss_local_xy_projection_core_macros.svh"
module glxy_ctrl
    import glxy_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int STEP_W       = $clog2(CORDIC_STEPS + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire t_status           i_status,
    output t_cmd                   o_cmd,
    output logic [STEP_W-1:0]      o_step
);
    t_state             r_state, n_state;
    logic [STEP_W-1:0]  r_cnt, n_cnt;
    t_mul_op            r_op, n_op;
    logic [1:0]         r_digit, n_digit;
    logic               r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_op        <= OP_PN_LAT;
            r_digit     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_op        <= n_op;
            r_digit     <= n_digit;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_op       = r_op;
        n_digit    = r_digit;
        o_cmd      = '0;
        o_cmd.mul_op    = r_op;
        o_cmd.mul_digit = r_digit;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = i_status.set_origin ? S_CINIT : S_CHECK;
            end
            S_CINIT: begin
                o_cmd.cordic_init = 1'b1;
                n_cnt   = '0;
                n_state = S_CORDIC;
            end
            S_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                if (r_cnt == STEP_W'(CORDIC_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_CFIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_CFIN: begin
                o_cmd.cordic_fin = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_op    = OP_PN_LAT;
                n_digit = '0;
                n_state = i_status.lv ? S_MUL : S_DONE;
            end
            S_MUL: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_first = (r_digit == 2'd0);
                o_cmd.mul_last  = (r_digit == 2'(NUM_DIGITS - 1));
                if (r_digit == 2'(NUM_DIGITS - 1)) begin
                    n_digit = '0;
                    if (r_op == OP_EAST)
                        n_state = S_DONE;
                    else
                        n_op = t_mul_op'(r_op + 1'b1);
                end else begin
                    n_digit = r_digit + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = (r_out_valid && !i_out_ready) || o_cmd.load_out;
    end

    assign o_step      = r_cnt;
    assign o_out_valid = r_out_valid;

    `GLXY_ASSERT_NXT(a_accept_decide, i_clk, i_rst_n, i_in_valid && o_in_ready,
        r_state == S_DECIDE, "accepted transfer not decoded next cycle")
    `GLXY_ASSERT_IMP(a_step_range, i_clk, i_rst_n, r_state == S_CORDIC,
        r_cnt < STEP_W'(CORDIC_STEPS), "CORDIC step out of range")
    `GLXY_ASSERT_IMP(a_digit_range, i_clk, i_rst_n, r_state == S_MUL,
        r_digit < 2'(NUM_DIGITS), "multiplier digit out of range")
    `GLXY_ASSERT_NXT(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !i_out_ready,
        r_out_valid, "pending result dropped")
endmodule
`default_nettype wire

@@ rtl/gnss_local_xy_projection_core.sv @@
// Top level of the GNSS local east/north projection core.
// Usage:
//  - Slave channel carries one request per transfer: tuser = req_type
//    (fix sample, set origin, set origin from last fix, clear origin),
//    tdata = lat_e7, lon_e7, fix_valid. Every request gives one result.
//  - Master channel returns east/north offsets in mm (saturated), the
//    local valid flag, the current origin, origin present and request ok.
//  - Config port: i_cfg_we writes register i_cfg_addr (0 auto origin,
//    1 east radius, 2 north radius) on the clock edge; write only while idle.
// A request runs decode, then a CORDIC cosine when it sets an origin (one
// CORDIC rotation per cycle), then a check; with projection it then runs
// five multiplies of 3 digits each on one shared 56x16 multiplier before
// its result is loaded. One request is worked on at a time. The next
// transfer is taken in the cycle after a result is loaded.
// The output register holds a finished result while the next request is
// taken in; a stalled receiver only holds the block once a second result
// is ready. Synchronous active-low reset clears origin, last fix and
// handshake state; config registers return to their reset values.
`default_nettype none
module gnss_local_xy_projection_core
    import glxy_pkg::*;
#(
    parameter int COS_FRAC_BITS = COS_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [1:0]             i_cfg_addr,
    input  wire logic [CFG_W-1:0]       i_cfg_wdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [30:0] lat_e7, [62:31] lon_e7, [63] fix_valid
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] req_type
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [35:0] east_mm, [71:36] north_mm, [72] local_valid, [103:73] origin latitude,
    // [135:104] origin longitude, [136] origin_present, [137] request_ok, rest zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);
    localparam int STEP_W = $clog2(CORDIC_STEPS + 1);

    t_cmd              cmd;
    t_status           status;
    logic [STEP_W-1:0] step;

    glxy_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .STEP_W       (STEP_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_step      (step)
    );

    glxy_datapath #(
        .COS_FRAC_BITS (COS_FRAC_BITS),
        .CORDIC_STEPS  (CORDIC_STEPS),
        .STEP_W        (STEP_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_tdata  (s_axis_tdata),
        .i_in_tuser  (s_axis_tuser),
        .i_cmd       (cmd),
        .i_step      (step),
        .o_status    (status),
        .o_out_tdata (m_axis_tdata)
    );
endmodule
`default_nettype wire
